/* rtl/rtdc_pkg.sv */
// Shared types, constants and PT1000 table functions for the RTD code-to-temperature unit.
package rtdc_pkg;

  localparam int ADC_BITS_DEF     = 24;
  localparam int TABLE_POINTS_DEF = 16;
  localparam int PT_AVAIL         = 16;

  localparam int REF_W    = 16;
  localparam logic [REF_W-1:0] REF_RESET = 16'd4020;

  localparam int RC_W     = REF_W + 7;   // centi-ohms, up to 65535*100
  localparam int TENTHS_W = 20;
  localparam int TEMP_W   = 15;
  localparam int SEG_W    = 4;

  localparam int D_W       = 13;          // resistance above segment's low point
  localparam int P_W       = 22;          // d * 1000
  localparam int SPAN_W    = 12;
  localparam int RECIP_W   = 11;
  localparam int RECIP_SHIFT = P_W;       // reciprocal is floor(2^22 / span)
  localparam int EST_W     = 11;
  localparam int REM_W     = 13;

  localparam int T_FIRST  = -5000;
  localparam int T_STEP   = 1000;
  localparam logic signed [TEMP_W-1:0] OOR_TEMP = 15'sd1000;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [TENTHS_W-1:0] tenths;
    logic [RC_W-1:0]     rc;
    logic [SEG_W-1:0]    seg;    // upper point of the interpolation segment
    logic                below;
    logic                above;
    logic                first;  // exactly on the first table point
  } rtdc_item_t;

  // PT1000 resistance in centi-ohms, -50 to 100 degC in 10 degC steps
  function automatic logic [RC_W-1:0] pt_centiohm(input int idx);
    logic [RC_W-1:0] v;
    case (idx)
      0:       v = RC_W'(80315);
      1:       v = RC_W'(84275);
      2:       v = RC_W'(88224);
      3:       v = RC_W'(92161);
      4:       v = RC_W'(96086);
      5:       v = RC_W'(100000);
      6:       v = RC_W'(103902);
      7:       v = RC_W'(107793);
      8:       v = RC_W'(111672);
      9:       v = RC_W'(115539);
      10:      v = RC_W'(119395);
      11:      v = RC_W'(123239);
      12:      v = RC_W'(127072);
      13:      v = RC_W'(130893);
      14:      v = RC_W'(134702);
      15:      v = RC_W'(138500);
      default: v = '0;
    endcase
    return v;
  endfunction

  // width of the segment ending at point idx
  function automatic logic [SPAN_W-1:0] seg_span(input int idx);
    logic [RC_W-1:0] hi;
    logic [RC_W-1:0] lo;
    hi = pt_centiohm(idx);
    lo = pt_centiohm(idx - 1);
    return SPAN_W'(hi - lo);
  endfunction

  // floor(2^22 / span) for the segment ending at point idx
  function automatic logic [RECIP_W-1:0] seg_recip(input int idx);
    logic [RECIP_W-1:0] v;
    case (idx)
      1:       v = RECIP_W'(1059);
      2:       v = RECIP_W'(1062);
      3:       v = RECIP_W'(1065);
      4:       v = RECIP_W'(1068);
      5:       v = RECIP_W'(1071);
      6:       v = RECIP_W'(1074);
      7:       v = RECIP_W'(1077);
      8:       v = RECIP_W'(1081);
      9:       v = RECIP_W'(1084);
      10:      v = RECIP_W'(1087);
      11:      v = RECIP_W'(1091);
      12:      v = RECIP_W'(1094);
      13:      v = RECIP_W'(1097);
      14:      v = RECIP_W'(1101);
      15:      v = RECIP_W'(1104);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [TEMP_W-1:0] pt_temp(input int idx);
    return TEMP_W'(T_FIRST + T_STEP * idx);
  endfunction

endpackage

/* rtl/rtd_code_to_temperature_unit.sv */
// Top level: configuration register, front end, request queue and interpolation back end.
// Throughput: one request per cycle; the back end drains the queue every cycle, so busy
// only rises if the two-entry queue fills, and the result side has no stall.
// Reset (rst_n low, synchronous): clears all valid bits and the queue, and sets
// reference_ohms to 4020.
module rtd_code_to_temperature_unit #(
  parameter int ADC_BITS     = rtdc_pkg::ADC_BITS_DEF,
  parameter int TABLE_POINTS = rtdc_pkg::TABLE_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [ADC_BITS-1:0]                 in_adc_code,
  output logic                                out_valid,
  output logic [rtdc_pkg::TENTHS_W-1:0]       out_resistance_tenths,
  output logic signed [rtdc_pkg::TEMP_W-1:0]  out_temperature_centi,
  output logic                                out_out_of_range,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rtdc_pkg::CFG_AW-1:0]         paddr,
  input  logic [rtdc_pkg::CFG_DW-1:0]         pwdata,
  output logic [rtdc_pkg::CFG_DW-1:0]         prdata,
  output logic                                pready
);
  import rtdc_pkg::*;

  localparam logic REG_REFERENCE_OHMS = 1'b0;

  logic [REF_W-1:0] ref_r;
  logic             cfg_wr;
  logic             q_full;
  logic             f_push;
  rtdc_item_t       f_item;
  logic             q_vld;
  rtdc_item_t       q_item;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_REFERENCE_OHMS) ? CFG_DW'(ref_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= REF_RESET;
    end else if (cfg_wr && paddr[2] == REG_REFERENCE_OHMS) begin
      ref_r <= pwdata[REF_W-1:0];
    end
  end

  assign busy = q_full;

  rtdc_front #(
    .ADC_BITS     (ADC_BITS),
    .TABLE_POINTS (TABLE_POINTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .adc_code (in_adc_code),
    .ref_ohms (ref_r),
    .adv      (~q_full),
    .push     (f_push),
    .item     (f_item)
  );

  rtdc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_push),
    .wdata   (f_item),
    .full    (q_full),
    .rd_vld  (q_vld),
    .rd_data (q_item)
  );

  rtdc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (q_vld),
    .in_item    (q_item),
    .out_valid  (out_valid),
    .out_tenths (out_resistance_tenths),
    .out_temp   (out_temperature_centi),
    .out_oor    (out_out_of_range)
  );

endmodule

/* rtl/rtdc_front.sv */
// Front end: scales the code to resistance, divides by full scale and picks the table segment.
module rtdc_front #(
  parameter int ADC_BITS     = rtdc_pkg::ADC_BITS_DEF,
  parameter int TABLE_POINTS = rtdc_pkg::TABLE_POINTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ADC_BITS-1:0]        adc_code,
  input  logic [rtdc_pkg::REF_W-1:0] ref_ohms,
  input  logic                       adv,
  output logic                       push,
  output rtdc_pkg::rtdc_item_t       item
);
  import rtdc_pkg::*;

  localparam int PW       = ADC_BITS + REF_W;
  localparam int XW       = PW + 7;
  localparam int QW       = XW - ADC_BITS;
  localparam int NFOLD    = 3;
  localparam int NSTG     = NFOLD + 4;
  localparam int PTS_USED = (TABLE_POINTS < PT_AVAIL) ? TABLE_POINTS : PT_AVAIL;
  localparam logic [XW-1:0] FS = XW'({ADC_BITS{1'b1}});

  logic [NSTG-1:0] vld_r;
  logic [PW-1:0]   prod_r;
  logic [XW-1:0]   x_r   [2];
  logic [XW-1:0]   r_r   [2][NFOLD];
  logic [QW-1:0]   q_r   [2][NFOLD];
  logic [XW-1:0]   r_nxt [2][NFOLD];
  logic [QW-1:0]   q_nxt [2][NFOLD];
  logic [QW-1:0]   quo_r [2];
  logic [QW-1:0]   quo_nxt [2];
  rtdc_item_t      item_r;
  rtdc_item_t      item_nxt;

  // x mod (2^N-1) folding: x = hi*2^N + lo  ->  hi + lo, quotient gains hi
  always_comb begin
    logic [XW-1:0] src;
    logic [QW-1:0] srcq;
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < NFOLD; k++) begin
        if (k == 0) begin
          src  = x_r[l];
          srcq = '0;
        end else begin
          src  = r_r[l][k-1];
          srcq = q_r[l][k-1];
        end
        r_nxt[l][k] = (src & FS) + XW'(src[XW-1:ADC_BITS]);
        q_nxt[l][k] = srcq + src[XW-1:ADC_BITS];
      end
      quo_nxt[l] = q_r[l][NFOLD-1] + QW'(r_r[l][NFOLD-1] >= FS);
    end
  end

  always_comb begin
    logic [RC_W-1:0] rc;
    rc = RC_W'(quo_r[1]);
    item_nxt.tenths = TENTHS_W'(quo_r[0]);
    item_nxt.rc     = rc;
    item_nxt.below  = rc < pt_centiohm(0);
    item_nxt.first  = rc == pt_centiohm(0);
    item_nxt.above  = rc > pt_centiohm(PTS_USED - 1);
    item_nxt.seg    = SEG_W'(PTS_USED - 1);
    // lowest point at or above rc wins
    for (int i = PTS_USED - 1; i >= 1; i--) begin
      if (pt_centiohm(i) >= rc) begin
        item_nxt.seg = SEG_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= PW'(adc_code) * PW'(ref_ohms);
      x_r[0] <= (XW'(prod_r) << 3) + (XW'(prod_r) << 1);
      x_r[1] <= (XW'(prod_r) << 6) + (XW'(prod_r) << 5) + (XW'(prod_r) << 2);
      for (int l = 0; l < 2; l++) begin
        for (int k = 0; k < NFOLD; k++) begin
          r_r[l][k] <= r_nxt[l][k];
          q_r[l][k] <= q_nxt[l][k];
        end
        quo_r[l] <= quo_nxt[l];
      end
      item_r <= item_nxt;
    end
  end

  assign push = vld_r[NSTG-1] & adv;
  assign item = item_r;

endmodule

/* rtl/rtdc_queue.sv */
// Two-entry request queue between the front end and the interpolation back end.
module rtdc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rtdc_pkg::rtdc_item_t wdata,
  output logic                 full,
  output logic                 rd_vld,
  output rtdc_pkg::rtdc_item_t rd_data
);
  import rtdc_pkg::*;

  rtdc_item_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W:0]   cnt_r;
  logic [Q_PTR_W:0]   cnt_nxt;
  logic               pop;

  assign full    = cnt_r == (Q_PTR_W+1)'(Q_DEPTH);
  assign rd_vld  = cnt_r != '0;
  assign pop     = rd_vld;    // back end never stalls
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* rtl/rtdc_back.sv */
// Back end: linear interpolation inside the chosen segment with an exact per-segment divide.
module rtdc_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_vld,
  input  rtdc_pkg::rtdc_item_t                in_item,
  output logic                                out_valid,
  output logic [rtdc_pkg::TENTHS_W-1:0]       out_tenths,
  output logic signed [rtdc_pkg::TEMP_W-1:0]  out_temp,
  output logic                                out_oor
);
  import rtdc_pkg::*;

  localparam int NB     = 5;
  localparam int PROD_W = P_W + RECIP_W;

  logic [NB-1:0]   vld_r;
  rtdc_item_t      it_r [NB];
  logic [D_W-1:0]  d_r;
  logic [P_W-1:0]  p2_r;
  logic [P_W-1:0]  p3_r;
  logic [EST_W-1:0] est3_r;
  logic [EST_W-1:0] est4_r;
  logic [REM_W-1:0] rem_r;
  logic [EST_W-1:0] f_r;
  logic             nz_r;

  logic [D_W-1:0]   d_nxt;
  logic [P_W-1:0]   p_nxt;
  logic [EST_W-1:0] est_nxt;
  logic [REM_W-1:0] rem_nxt;
  logic [EST_W-1:0] f_nxt;
  logic             nz_nxt;

  logic                       valid_r;
  logic [TENTHS_W-1:0]        tenths_r;
  logic signed [TEMP_W-1:0]   temp_r;
  logic signed [TEMP_W-1:0]   temp_nxt;
  logic                       oor_r;

  always_comb begin
    logic [RC_W-1:0]    lo;
    logic [PROD_W-1:0]  prod;
    logic [P_W-1:0]     esp;
    logic [REM_W-1:0]   span4;
    logic [REM_W-1:0]   span5;
    logic               corr;
    logic signed [TEMP_W-1:0] sum;

    lo    = pt_centiohm(int'(in_item.seg) - 1);
    d_nxt = D_W'(in_item.rc - lo);

    // d * 1000
    p_nxt = (P_W'(d_r) << 10) - (P_W'(d_r) << 4) - (P_W'(d_r) << 3);

    // reciprocal estimate is exact or one low
    prod    = PROD_W'(p2_r) * PROD_W'(seg_recip(int'(it_r[1].seg)));
    est_nxt = prod[PROD_W-1:RECIP_SHIFT];

    span4   = REM_W'(seg_span(int'(it_r[2].seg)));
    esp     = P_W'(est3_r) * P_W'(span4);
    rem_nxt = REM_W'(p3_r - esp);

    span5  = REM_W'(seg_span(int'(it_r[3].seg)));
    corr   = rem_r >= span5;
    f_nxt  = est4_r + EST_W'(corr);
    nz_nxt = corr ? (rem_r != span5) : (rem_r != '0);

    // truncate toward zero: a negative inexact result rounds up
    sum = pt_temp(int'(it_r[4].seg) - 1) + $signed(TEMP_W'(f_r));
    if (it_r[4].below || it_r[4].above) begin
      temp_nxt = OOR_TEMP;
    end else if (it_r[4].first) begin
      temp_nxt = pt_temp(0);
    end else if (sum[TEMP_W-1] && nz_r) begin
      temp_nxt = sum + TEMP_W'(1);
    end else begin
      temp_nxt = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      vld_r   <= {vld_r[NB-2:0], in_vld};
      valid_r <= vld_r[NB-1];
    end
  end

  always_ff @(posedge clk) begin
    it_r[0] <= in_item;
    for (int k = 1; k < NB; k++) begin
      it_r[k] <= it_r[k-1];
    end
    d_r      <= d_nxt;
    p2_r     <= p_nxt;
    p3_r     <= p2_r;
    est3_r   <= est_nxt;
    est4_r   <= est3_r;
    rem_r    <= rem_nxt;
    f_r      <= f_nxt;
    nz_r     <= nz_nxt;
    tenths_r <= it_r[NB-1].tenths;
    temp_r   <= temp_nxt;
    oor_r    <= it_r[NB-1].below | it_r[NB-1].above;
  end

  assign out_valid  = valid_r;
  assign out_tenths = tenths_r;
  assign out_temp   = temp_r;
  assign out_oor    = oor_r;

endmodule

/* test/rtd_code_to_temperature_unit_test.sv */
// Self-checking testbench for the RTD code-to-temperature unit: directed rows, random codes.
module rtd_code_to_temperature_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADC_W    = rtdc_pkg::ADC_BITS_DEF;
  localparam int TENTHS_W = rtdc_pkg::TENTHS_W;
  localparam int TEMP_W   = rtdc_pkg::TEMP_W;
  localparam int CFG_AW   = rtdc_pkg::CFG_AW;
  localparam int CFG_DW   = rtdc_pkg::CFG_DW;

  localparam longint FULL_SCALE = 64'hFFFFFF;
  localparam int NUM_POINTS = 16;
  localparam int FIRST_TEMP = -5000;
  localparam int STEP_TEMP  = 1000;
  localparam int FLAG_TEMP  = 1000;
  localparam logic [CFG_AW-1:0] REG_REFERENCE_OHMS = '0;
  localparam int DRAIN_CYCLES = 20;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 165;

  typedef struct packed {
    logic [TENTHS_W-1:0]       tenths;
    logic signed [TEMP_W-1:0]  temp_centi;
    logic                      oor;
  } reading_t;

  // pt >= 0 picks a code landing on table point pt plus delta centi-ohms
  typedef struct packed {
    logic [15:0]      ohms;
    int               pt;
    int               delta;
    logic [ADC_W-1:0] code;
    logic             typed;
    reading_t         result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [ADC_W-1:0] in_adc_code = '0;
  logic out_valid;
  logic [TENTHS_W-1:0] out_resistance_tenths;
  logic signed [TEMP_W-1:0] out_temperature_centi;
  logic out_out_of_range;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  logic have_typed = 1'b0;
  reading_t typed_reading = '0;
  logic [15:0] reference_ohms_model = 16'd4020;
  reading_t pending_readings[$];
  stim_row_t directed_rows[$];
  int mismatches = 0;
  int cycle_count = 0;

  rtd_code_to_temperature_unit uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_adc_code           (in_adc_code),
    .out_valid             (out_valid),
    .out_resistance_tenths (out_resistance_tenths),
    .out_temperature_centi (out_temperature_centi),
    .out_out_of_range      (out_out_of_range),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // PT1000 resistance in centi-ohms, -50 to 100 degC
  function automatic longint pt1000_point(input int i);
    longint v;
    case (i)
      0:  v = 80315;
      1:  v = 84275;
      2:  v = 88224;
      3:  v = 92161;
      4:  v = 96086;
      5:  v = 100000;
      6:  v = 103902;
      7:  v = 107793;
      8:  v = 111672;
      9:  v = 115539;
      10: v = 119395;
      11: v = 123239;
      12: v = 127072;
      13: v = 130893;
      14: v = 134702;
      default: v = 138500;
    endcase
    return v;
  endfunction

  function automatic reading_t convert_code(input logic [ADC_W-1:0] code,
                                            input logic [15:0] ohms);
    longint scaled;
    longint rc;
    longint rlo;
    longint span;
    longint tlo;
    longint num;
    int seg;
    reading_t r;
    scaled = longint'(code) * longint'(ohms);
    r.tenths = TENTHS_W'((scaled * 10) / FULL_SCALE);
    rc = (scaled * 100) / FULL_SCALE;
    r.temp_centi = TEMP_W'(FLAG_TEMP);
    r.oor = 1'b1;
    seg = -1;
    for (int i = 0; i < NUM_POINTS; i++)
      if (seg < 0 && pt1000_point(i) >= rc) seg = i;
    if (seg == 0) begin
      // first point is inclusive, anything below it is flagged
      if (rc == pt1000_point(0)) begin
        r.temp_centi = TEMP_W'(FIRST_TEMP);
        r.oor = 1'b0;
      end
    end else if (seg > 0) begin
      rlo = pt1000_point(seg - 1);
      span = pt1000_point(seg) - rlo;
      tlo = FIRST_TEMP + STEP_TEMP * (seg - 1);
      num = tlo * span + (rc - rlo) * STEP_TEMP;
      r.temp_centi = TEMP_W'(num / span);   // truncates toward zero
      r.oor = 1'b0;
    end
    return r;
  endfunction

  // smallest code whose centi-ohm resistance reaches target; exact since ohms*100 < FS
  function automatic logic [ADC_W-1:0] code_for_rc(input longint target,
                                                   input logic [15:0] ohms);
    longint per;
    longint c;
    if (ohms == 0 || target <= 0) return '0;
    per = longint'(ohms) * 100;
    c = (target * FULL_SCALE + per - 1) / per;
    if (c > FULL_SCALE) c = FULL_SCALE;
    return ADC_W'(c);
  endfunction

  function automatic logic [ADC_W-1:0] pick_code(input logic [15:0] ohms);
    int r;
    int pt;
    longint target;
    logic [ADC_W-1:0] c;
    r = $urandom_range(0, 99);
    if (r < 55 && longint'(ohms) * 100 >= pt1000_point(0) - 100) begin
      pt = $urandom_range(0, NUM_POINTS - 1);
      target = pt1000_point(pt);
      case ($urandom_range(0, 3))
        0:       target = target;
        1:       target = target + 1;
        2:       target = target - 1;
        default: target = target + $urandom_range(0, 4000) - 100;
      endcase
      c = code_for_rc(target, ohms);
    end else if (r < 75) begin
      c = ADC_W'($urandom);
    end else if (r < 85) begin
      case ($urandom_range(0, 3))
        0:       c = '0;
        1:       c = '1;
        2:       c = ADC_W'(FULL_SCALE - 1);
        default: c = ADC_W'(1);
      endcase
    end else begin
      c = ADC_W'(1) << $urandom_range(0, ADC_W - 1);
      if ($urandom_range(0, 1) == 1) c = ~c;
    end
    return c;
  endfunction

  task automatic add_row(input logic [15:0] ohms, input int pt, input int delta,
                         input logic [ADC_W-1:0] code, input logic typed,
                         input int tenths, input int temp, input logic oor);
    stim_row_t row;
    row.ohms = ohms;
    row.pt = pt;
    row.delta = delta;
    row.code = code;
    row.typed = typed;
    row.result.tenths = TENTHS_W'(tenths);
    row.result.temp_centi = TEMP_W'(temp);
    row.result.oor = oor;
    directed_rows.push_back(row);
  endtask

  task automatic apb_access(input logic wr, input logic [CFG_DW-1:0] data,
                            output logic [CFG_DW-1:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= REG_REFERENCE_OHMS;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_reference(input logic [15:0] ohms);
    logic [CFG_DW-1:0] rd;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    apb_access(1'b1, CFG_DW'(ohms), rd);
    reference_ohms_model = ohms;
    apb_access(1'b0, '0, rd);
    if (rd != CFG_DW'(ohms)) begin
      $error("reference_ohms: expected %0d, got %0d", ohms, rd);
      mismatches++;
    end
  endtask

  // leaves start high; caller either sends again or lowers it
  task automatic send_code(input logic [ADC_W-1:0] code, input logic bursty,
                           input logic typed, input reading_t typed_in);
    int gap;
    gap = 0;
    if (bursty && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
    if (gap > 0) begin
      start <= 1'b0;
      in_adc_code <= ADC_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_adc_code <= code;
    have_typed <= typed;
    typed_reading <= typed_in;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_readings.size() == 0) begin
          $error("unexpected result: tenths %0d temp %0d flag %0b", out_resistance_tenths,
                 out_temperature_centi, out_out_of_range);
          mismatches++;
        end else begin
          want = pending_readings.pop_front();
          if (out_resistance_tenths !== want.tenths) begin
            $error("resistance_tenths: expected %0d, got %0d", want.tenths,
                   out_resistance_tenths);
            mismatches++;
          end
          if (out_temperature_centi !== want.temp_centi) begin
            $error("temperature_centi: expected %0d, got %0d", want.temp_centi,
                   out_temperature_centi);
            mismatches++;
          end
          if (out_out_of_range !== want.oor) begin
            $error("out_of_range: expected %0b, got %0b", want.oor, out_out_of_range);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        if (have_typed) pending_readings.push_back(typed_reading);
        else pending_readings.push_back(convert_code(in_adc_code, reference_ohms_model));
      end
    end
  end

  initial begin
    stim_row_t row;
    logic [ADC_W-1:0] code;
    logic [15:0] ohms;
    // ohms, point, delta, code, typed, tenths, temp, flag
    add_row(16'd4020, -1, 0, 24'h000000, 1'b1, 0, FLAG_TEMP, 1'b1);
    add_row(16'd4020, -1, 0, 24'hFFFFFF, 1'b1, 40200, FLAG_TEMP, 1'b1);
    add_row(16'd4020, 0, -1, '0, 1'b0, 0, 0, 1'b0);       // just below the table
    add_row(16'd4020, 0, 0, '0, 1'b0, 0, 0, 1'b0);        // exactly the first point
    add_row(16'd4020, 0, 1, '0, 1'b0, 0, 0, 1'b0);
    add_row(16'd4020, 7, 0, '0, 1'b0, 0, 0, 1'b0);        // interior point
    add_row(16'd4020, 7, 1234, '0, 1'b0, 0, 0, 1'b0);
    add_row(16'd4020, 3, 2000, '0, 1'b0, 0, 0, 1'b0);
    add_row(16'd4020, 14, 1900, '0, 1'b0, 0, 0, 1'b0);
    add_row(16'd4020, 15, 0, '0, 1'b0, 0, 0, 1'b0);       // last point
    add_row(16'd4020, 15, 1, '0, 1'b0, 0, 0, 1'b0);       // just above the table
    add_row(16'd4020, -1, 0, 24'h800000, 1'b0, 0, 0, 1'b0);
    add_row(16'd4020, -1, 0, 24'h555555, 1'b0, 0, 0, 1'b0);
    add_row(16'd4020, -1, 0, 24'hAAAAAA, 1'b0, 0, 0, 1'b0);
    add_row(16'd0, -1, 0, 24'hFFFFFF, 1'b1, 0, FLAG_TEMP, 1'b1);   // zero reference
    add_row(16'd0, -1, 0, 24'h000000, 1'b1, 0, FLAG_TEMP, 1'b1);
    add_row(16'd65535, -1, 0, 24'hFFFFFF, 1'b1, 655350, FLAG_TEMP, 1'b1);
    add_row(16'd65535, 0, 0, '0, 1'b0, 0, 0, 1'b0);
    add_row(16'd65535, 8, -1, '0, 1'b0, 0, 0, 1'b0);
    add_row(16'd65535, 15, 0, '0, 1'b0, 0, 0, 1'b0);
    add_row(16'd1, -1, 0, 24'hFFFFFF, 1'b1, 10, FLAG_TEMP, 1'b1);
    add_row(16'd1, -1, 0, 24'h000001, 1'b1, 0, FLAG_TEMP, 1'b1);
    add_row(16'd1000, -1, 0, 24'hFFFFFF, 1'b1, 10000, 0, 1'b0);    // full scale on 0 degC
    add_row(16'd1000, 5, -1, '0, 1'b0, 0, 0, 1'b0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.ohms != reference_ohms_model) begin
        start <= 1'b0;
        set_reference(row.ohms);
      end
      code = (row.pt >= 0) ? code_for_rc(pt1000_point(row.pt) + row.delta, row.ohms)
                           : row.code;
      send_code(code, 1'b1, row.typed, row.result);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       ohms = 16'd65535;
        1:       ohms = 16'd1;
        2:       ohms = 16'd4020;
        3:       ohms = 16'($urandom_range(0, 65535));
        default: ohms = 16'($urandom_range(800, 65535));
      endcase
      start <= 1'b0;
      set_reference(ohms);
      // the last phase runs without gaps
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_code(pick_code(ohms), p != PHASES - 1, 1'b0, '0);
    end
    start <= 1'b0;

    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
